>>> rtl/rrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrl_pkg
// Shared types, codes and reset values for the recorder remote link block.
// ----------------------------------------------------------------------------
package rrl_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 24;

  // register index codes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_ACK_BYTE        = 3'd0,
    REG_LED_HEADER_BYTE = 3'd1,
    REG_HANDSHAKE_REPLY = 3'd2,
    REG_TIMEOUT_RELOAD  = 3'd3,
    REG_RECORD_ON_THR   = 3'd4,
    REG_RECORD_OFF_THR  = 3'd5
  } rrl_reg_idx_t;

  // link phases
  typedef enum logic [2:0] {
    PH_CONNECT   = 3'd0,
    PH_HANDSHAKE = 3'd1,
    PH_WATCH     = 3'd2,
    PH_IDLE      = 3'd3,
    PH_PUSH      = 3'd4,
    PH_CONFIRM   = 3'd5
  } rrl_phase_t;

  // message codes
  typedef enum logic [2:0] {
    SEND_NONE   = 3'd0,
    SEND_WAKE   = 3'd1,
    SEND_HELLO  = 3'd2,
    SEND_RECORD = 3'd3,
    SEND_STOP   = 3'd4
  } rrl_send_t;

  localparam logic [7:0]         AckByteReset       = 8'h82;
  localparam logic [7:0]         LedHeaderReset     = 8'h84;
  localparam logic [23:0]        HandshakeReset     = 24'h000000;
  localparam logic [7:0]         TimeoutReset       = 8'd10;
  localparam logic signed [15:0] RecordOnThrReset   = -16'sd28672;
  localparam logic signed [15:0] RecordOffThrReset  = -16'sd20480;

  typedef struct packed {
    logic [7:0]         ack_byte;
    logic [7:0]         led_header_byte;
    logic [23:0]        handshake_reply_word;
    logic [7:0]         timeout_reload;
    logic signed [15:0] record_on_threshold;
    logic signed [15:0] record_off_threshold;
  } rrl_cfg_t;

  typedef struct packed {
    logic [1:0]         rx_available;
    logic [7:0]         rx_byte0;
    logic [7:0]         rx_byte1;
    logic [7:0]         rx_byte2;
    logic               control_valid;
    logic signed [15:0] control_value;
  } rrl_in_t;

  typedef struct packed {
    logic [2:0] send_code;
    logic [1:0] consume_count;
    logic       flush_rx;
    logic [2:0] link_state;
    logic       recording_seen;
    logic       recording_wanted;
  } rrl_out_t;

endpackage
`default_nettype wire

>>> rtl/recorder_remote_link_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// recorder_remote_link_fsm
// Tick-stepped link controller for a remote recorder.
// ----------------------------------------------------------------------------
// Each input transfer is one scheduler tick and yields exactly one result
// transfer. The block takes one tick per clock while the output is not
// stalled: an input register feeds a combinational state update (phase,
// reply countdown, LED and wish flags) whose result lands in an output
// register, and a stalled output holds both registers without losing a tick.
// Configuration writes take effect on the next clock.
// ----------------------------------------------------------------------------
module recorder_remote_link_fsm
  import rrl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire rrl_in_t                  in_data,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output rrl_out_t                      out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_wdata
);

  rrl_cfg_t cfg;
  rrl_in_t  s1_data;
  logic     s1_valid;
  logic     advance;
  rrl_out_t result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  rrl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rrl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (s1_data),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // result register, held until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rrl_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrl_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module rrl_cfg_regs
  import rrl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_wdata,
  output rrl_cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_byte             <= AckByteReset;
      cfg.led_header_byte      <= LedHeaderReset;
      cfg.handshake_reply_word <= HandshakeReset;
      cfg.timeout_reload       <= TimeoutReset;
      cfg.record_on_threshold  <= RecordOnThrReset;
      cfg.record_off_threshold <= RecordOffThrReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACK_BYTE:        cfg.ack_byte             <= cfg_wdata[7:0];
        REG_LED_HEADER_BYTE: cfg.led_header_byte      <= cfg_wdata[7:0];
        REG_HANDSHAKE_REPLY: cfg.handshake_reply_word <= cfg_wdata[23:0];
        REG_TIMEOUT_RELOAD:  cfg.timeout_reload       <= cfg_wdata[7:0];
        REG_RECORD_ON_THR:   cfg.record_on_threshold  <= $signed(cfg_wdata[15:0]);
        REG_RECORD_OFF_THR:  cfg.record_off_threshold <= $signed(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/rrl_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrl_core
// Link state machine: phase, reply countdown, LED and wish flags, plus the
// per-tick result computed from the registered input item.
// ----------------------------------------------------------------------------
module rrl_core
  import rrl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step_en,
  input  wire rrl_in_t  item,
  input  wire rrl_cfg_t cfg,
  output rrl_out_t      result
);

  rrl_phase_t phase, phase_next, phase_eff;
  logic [7:0] countdown, countdown_next, countdown_dec;
  logic       led_rec, led_rec_next;
  logic       want, want_next;
  logic       hs_match;
  logic [2:0] send;
  logic [1:0] consume;
  logic       flush;

  // control sample with hysteresis, the on test wins on overlap
  always_comb begin
    want_next = want;
    if (item.control_valid) begin
      if (item.control_value <= cfg.record_on_threshold) begin
        want_next = 1'b1;
      end else if (item.control_value >= cfg.record_off_threshold) begin
        want_next = 1'b0;
      end
    end
  end

  assign phase_eff     = (want_next != want) ? PH_PUSH : phase;
  assign countdown_dec = (countdown != 8'd0) ? countdown - 8'd1 : 8'd0;
  assign hs_match      = (item.rx_available == 2'd3) &&
                         ({item.rx_byte0, item.rx_byte1, item.rx_byte2} ==
                          cfg.handshake_reply_word);

  // next state
  always_comb begin
    phase_next     = PH_CONNECT;
    countdown_next = countdown_dec;
    led_rec_next   = led_rec;
    unique case (phase_eff)
      PH_CONNECT: begin
        if (item.rx_available != 2'd0 && item.rx_byte0 == cfg.ack_byte) begin
          countdown_next = cfg.timeout_reload;
          phase_next     = PH_HANDSHAKE;
        end else begin
          phase_next = PH_CONNECT;
        end
      end
      PH_HANDSHAKE: begin
        if (hs_match) begin
          phase_next = PH_PUSH;
        end else if (countdown_dec == 8'd0) begin
          phase_next = PH_CONNECT;
        end else begin
          phase_next = PH_HANDSHAKE;
        end
      end
      PH_WATCH: begin
        if (item.rx_available == 2'd3) begin
          if (item.rx_byte0 != cfg.led_header_byte) begin
            phase_next = PH_CONNECT;
          end else begin
            led_rec_next   = item.rx_byte1[0];
            countdown_next = cfg.timeout_reload;
            phase_next     = PH_WATCH;
          end
        end else if (countdown_dec == 8'd0) begin
          if (item.rx_available != 2'd0) begin
            phase_next = PH_CONNECT;
          end else if (led_rec != want_next) begin
            phase_next = PH_PUSH;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          phase_next = PH_WATCH;
        end
      end
      PH_IDLE: begin
        phase_next = (item.rx_available != 2'd0) ? PH_WATCH : PH_IDLE;
      end
      PH_PUSH: begin
        countdown_next = cfg.timeout_reload;
        phase_next     = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (item.rx_available != 2'd0) begin
          phase_next = PH_WATCH;
        end else if (countdown_dec == 8'd0) begin
          phase_next = PH_CONNECT;
        end else begin
          phase_next = PH_CONFIRM;
        end
      end
      default: phase_next = PH_CONNECT;
    endcase
  end

  // per-tick actions
  always_comb begin
    send    = SEND_NONE;
    consume = 2'd0;
    flush   = 1'b0;
    unique case (phase_eff)
      PH_CONNECT: begin
        if (item.rx_available != 2'd0 && item.rx_byte0 == cfg.ack_byte) begin
          consume = 2'd1;
          send    = SEND_HELLO;
        end else begin
          flush = 1'b1;
          send  = SEND_WAKE;
        end
      end
      PH_HANDSHAKE: begin
        if (hs_match) begin
          consume = 2'd3;
        end
      end
      PH_WATCH: begin
        if (item.rx_available == 2'd3) begin
          consume = 2'd3;
        end
      end
      PH_PUSH: begin
        send = want_next ? SEND_RECORD : SEND_STOP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CONNECT;
      countdown <= 8'd0;
      led_rec   <= 1'b0;
      want      <= 1'b0;
    end else if (step_en) begin
      phase     <= phase_next;
      countdown <= countdown_next;
      led_rec   <= led_rec_next;
      want      <= want_next;
    end
  end

  assign result.send_code        = send;
  assign result.consume_count    = consume;
  assign result.flush_rx         = flush;
  assign result.link_state       = phase_next;
  assign result.recording_seen   = led_rec_next;
  assign result.recording_wanted = want_next;

endmodule
`default_nettype wire
